FILE: hw/rtl/dsrp_pkg.sv
// shared constants, codes and cell control types of the data stack
`default_nettype none

package dsrp_pkg;

  // stack geometry
  localparam int unsigned StackDepth = 1024;
  localparam int unsigned CountW     = $clog2(StackDepth + 1);
  localparam int unsigned PosW       = $clog2(StackDepth);

  // item field widths
  localparam int unsigned WordW  = 32;
  localparam int unsigned OpW    = 3;
  localparam int unsigned DepthW = 11;
  localparam int unsigned ErrW   = 2;

  // operation codes
  localparam logic [OpW-1:0] OpPush  = 3'd0;
  localparam logic [OpW-1:0] OpPop   = 3'd1;
  localparam logic [OpW-1:0] OpPeek  = 3'd2;
  localparam logic [OpW-1:0] OpPick  = 3'd3;
  localparam logic [OpW-1:0] OpRoll  = 3'd4;
  localparam logic [OpW-1:0] OpClear = 3'd5;

  // error codes
  localparam logic [ErrW-1:0] ErrNone  = 2'd0;
  localparam logic [ErrW-1:0] ErrUnder = 2'd1;
  localparam logic [ErrW-1:0] ErrOver  = 2'd2;

  // per-cycle command broadcast to every cell
  typedef enum logic [2:0] {
    CellHold,  // keep the word
    CellPush,  // take the word of the cell above (top takes the pushed word)
    CellPop,   // take the word of the cell below
    CellDup,   // cells at or above pos take from below, the rest hold
    CellSwap   // cells pos and pos+1 exchange their words
  } cell_op_e;

  typedef struct packed {
    cell_op_e        op;
    logic [PosW-1:0] pos;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dsrp_cell.sv
// one stack cell: a word register that loads from itself or a neighbor
`default_nettype none

module dsrp_cell (
  input  wire logic                     clk_i,
  input  wire logic [dsrp_pkg::PosW-1:0]  idx_i,
  input  wire dsrp_pkg::cell_ctrl_t     ctrl_i,
  input  wire logic [dsrp_pkg::WordW-1:0] prev_i,
  input  wire logic [dsrp_pkg::WordW-1:0] next_i,
  output logic      [dsrp_pkg::WordW-1:0] data_o
);
  import dsrp_pkg::*;

  logic [WordW-1:0] data_q, data_d;
  logic [PosW-1:0]  idx_m1;

  assign idx_m1 = idx_i - PosW'(1);

  // select the source of the next word
  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CellPush: data_d = prev_i;
      CellPop:  data_d = next_i;
      CellDup: begin
        if (idx_i <= ctrl_i.pos) data_d = next_i;
      end
      CellSwap: begin
        if (idx_i == ctrl_i.pos) begin
          data_d = next_i;
        end else if ((idx_i != '0) && (idx_m1 == ctrl_i.pos)) begin
          data_d = prev_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // word register, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/data_stack_with_roll_pick.sv
// data stack with pick and roll: cell chain, op decoder and result register
//
//  channel | direction | handshake              | fields
//  --------+-----------+------------------------+---------------------------------
//  in      | input     | in_valid_i/in_ready_o  | op_i, value_i
//  out     | output    | out_valid_o/out_ready_i| data_o, depth_o, error_code_o
//
// push, pop, peek, clear, pick 0, roll 0 and any failing pick or roll load
// their result as they are taken. other picks and rolls run in steps: the first
// pops the index (pick also duplicates item n in place), then the item bubbles
// up one cell per cycle through neighbor swaps in the cell chain.
// reset clears count, state and out_valid; cell words are undefined until pushed.
// one item is in flight at a time; a new item is taken once the result
// register is empty or being drained in the same cycle.
`default_nettype none

module data_stack_with_roll_pick (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic        [dsrp_pkg::OpW-1:0]   op_i,
  input  wire logic signed [dsrp_pkg::WordW-1:0] value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed      [dsrp_pkg::WordW-1:0] data_o,
  output logic             [dsrp_pkg::DepthW-1:0] depth_o,
  output logic             [dsrp_pkg::ErrW-1:0]  error_code_o
);
  import dsrp_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StBusy = 1'b1;

  logic             state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [PosW-1:0]  pos_q, pos_d;
  cell_ctrl_t       ctrl;

  logic [WordW-1:0] cell_data [StackDepth];
  logic [WordW-1:0] top_word;
  logic [CountW-1:0] count_m1;
  logic             in_fire;
  logic             empty;
  logic             full;
  logic             idx_ok;
  logic [PosW-1:0]  idx_pos;

  logic             res_load;
  logic [WordW-1:0] res_data;
  logic [ErrW-1:0]  res_err;

  logic             out_valid_q;
  logic [WordW-1:0] out_data_q;
  logic [DepthW-1:0] out_depth_q;
  logic [ErrW-1:0]  out_err_q;

  // chain of cells, top of stack at cell 0
  for (genvar k = 0; k < StackDepth; k++) begin : g_cell
    logic [WordW-1:0] prev_w;
    logic [WordW-1:0] next_w;
    if (k == 0) begin : g_top
      assign prev_w = $unsigned(value_i);
    end else begin : g_mid
      assign prev_w = cell_data[k-1];
    end
    if (k == StackDepth - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_inner
      assign next_w = cell_data[k+1];
    end
    dsrp_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (PosW'(k)),
      .ctrl_i (ctrl),
      .prev_i (prev_w),
      .next_i (next_w),
      .data_o (cell_data[k])
    );
  end

  // status of the stack and of the index operand on top
  assign top_word = cell_data[0];
  assign count_m1 = count_q - CountW'(1);
  assign empty    = (count_q == '0);
  assign full     = (count_q == CountW'(StackDepth));
  assign idx_ok   = !top_word[WordW-1] &&
                    (top_word[WordW-2:0] < (WordW-1)'(count_m1));
  assign idx_pos  = top_word[PosW-1:0];

  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  // op decode and swap sequencer
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    pos_d    = pos_q;
    ctrl.op  = CellHold;
    ctrl.pos = pos_q;
    res_load = 1'b0;
    res_data = '0;
    res_err  = ErrNone;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          res_load = 1'b1;
          case (op_i)
            OpPush: begin
              if (full) begin
                res_err = ErrOver;
              end else begin
                ctrl.op = CellPush;
                count_d = count_q + CountW'(1);
              end
            end
            OpPop: begin
              if (empty) begin
                res_err = ErrUnder;
              end else begin
                ctrl.op  = CellPop;
                count_d  = count_m1;
                res_data = top_word;
              end
            end
            OpPeek: begin
              if (empty) res_err = ErrUnder;
              else res_data = top_word;
            end
            OpPick, OpRoll: begin
              if (empty) begin
                res_err = ErrUnder;
              end else if (!idx_ok) begin
                ctrl.op = CellPop;
                count_d = count_m1;
                res_err = ErrUnder;
              end else begin
                ctrl.pos = idx_pos;
                if (op_i == OpPick) begin
                  // pop the index and duplicate item n in one step
                  ctrl.op = CellDup;
                  count_d = count_q;
                end else begin
                  ctrl.op = CellPop;
                  count_d = count_m1;
                end
                if (idx_pos != '0) begin
                  res_load = 1'b0;
                  state_d  = StBusy;
                  pos_d    = idx_pos - PosW'(1);
                end
              end
            end
            OpClear: count_d = '0;
            default: res_data = '0;
          endcase
        end
      end
      StBusy: begin
        // bubble the item one cell toward the top
        ctrl.op  = CellSwap;
        ctrl.pos = pos_q;
        if (pos_q == '0) begin
          res_load = 1'b1;
          state_d  = StIdle;
        end else begin
          pos_d = pos_q - PosW'(1);
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      if (res_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_data_q  <= res_data;
      out_depth_q <= DepthW'(count_d);
      out_err_q   <= res_err;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_o       = $signed(out_data_q);
  assign depth_o      = out_depth_q;
  assign error_code_o = out_err_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(StackDepth))
    else $error("item count above stack depth");

  a_busy_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StBusy) |-> !out_valid_q)
    else $error("result pending while a swap sequence runs");

  a_busy_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StBusy) |=> $stable(count_q))
    else $error("item count changed during a swap sequence");

  a_err_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (error_code_o != ErrNone)) |-> (data_o == '0))
    else $error("error result carries data");

  a_over_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (error_code_o == ErrOver)) |-> (depth_o == DepthW'(StackDepth)))
    else $error("overflow reported below full depth");

endmodule

`default_nettype wire
